>>> rtl/csc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock/countdown/stopwatch controller package
// Event codes, field widths and the wrapping knob-step helper.
// ----------------------------------------------------------------------------
package csc_pkg;

	// event codes carried in s_tuser
	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_KNOB_FWD = 3'd1;
	localparam logic [2:0] OP_KNOB_BWD = 3'd2;
	localparam logic [2:0] OP_KNOB_PRS = 3'd3;
	localparam logic [2:0] OP_KEY_ONE  = 3'd4;
	localparam logic [2:0] OP_KEY_TWO  = 3'd5;

	// setting field selectors
	localparam logic [2:0] SF_YEAR   = 3'd0;
	localparam logic [2:0] SF_MONTH  = 3'd1;
	localparam logic [2:0] SF_DAY    = 3'd2;
	localparam logic [2:0] SF_HOUR   = 3'd3;
	localparam logic [2:0] SF_MINUTE = 3'd4;
	localparam logic [2:0] SF_SECOND = 3'd5;

	// preset field selectors
	localparam logic [1:0] PF_HOUR   = 2'd0;
	localparam logic [1:0] PF_MINUTE = 2'd1;
	localparam logic [1:0] PF_SECOND = 2'd2;

	localparam logic [15:0] TPS_RESET = 16'd1000;
	localparam logic [7:0]  YEAR_MIN  = 8'd70;
	localparam logic [7:0]  YEAR_MAX  = 8'd199;
	localparam logic [5:0]  MONTH_MAX = 6'd11;
	localparam logic [5:0]  DAY_MIN   = 6'd1;
	localparam logic [5:0]  DAY_MAX   = 6'd31;
	localparam logic [5:0]  HOUR_MAX  = 6'd23;
	localparam logic [5:0]  MS_MAX    = 6'd59;
	localparam logic [6:0]  WATCH_HOUR_MAX = 7'd99;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 48;

	// one knob step with wrap at both ends
	function automatic logic [5:0] step_wrap(input logic [5:0] v, input logic [5:0] lo,
			input logic [5:0] hi, input logic fwd);
		if (fwd) begin
			return (v >= hi) ? lo : v + 6'd1;
		end
		return (v <= lo) ? hi : v - 6'd1;
	endfunction

endpackage

>>> rtl/clock_set_countdown_stopwatch_ctrl_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock set / countdown / stopwatch controller
// Five-mode event-driven controller for a clock display unit.
// ----------------------------------------------------------------------------
// Takes one event per item (tick, knob step/press, key one/two) together with
// the current RTC reading, and returns one item per event describing the
// display after it. An item is registered on input, the mode/state update
// runs combinationally between that register and the result register, and
// one item is accepted every cycle while the output flows; the result
// register only stalls the input when it is full and not being taken.
// ticks_per_second (reset 1000, 0 acts as 1) may be written only while idle.
module clock_set_countdown_stopwatch_ctrl_unit
	import csc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [15:0]           cfg_wr_data,  // ticks_per_second
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [2:0]            s_tuser,      // op
	// rtc_year[7:0], rtc_month[11:8], rtc_day[16:12], rtc_hour[21:17],
	// rtc_minute[27:22], rtc_second[33:28], zero fill[39:34]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [2:0]            m_tuser,      // mode
	// cursor_field[2:0], disp_year[10:3], disp_month[14:11], disp_day[19:15],
	// disp_hour[26:20], disp_minute[32:27], disp_second[38:33], rtc_write[39],
	// hold_lamp[40], alarm[41], zero fill[47:42]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	typedef enum logic [2:0] {
		MODE_NORMAL  = 3'd0,
		MODE_SETTING = 3'd1,
		MODE_PRESET  = 3'd2,
		MODE_RUN     = 3'd3,
		MODE_WATCH   = 3'd4
	} mode_t;

	// input stage
	logic        valid_s1;
	logic [2:0]  op_s1;
	logic [7:0]  ry_s1;
	logic [3:0]  rmo_s1;
	logic [4:0]  rd_s1;
	logic [4:0]  rh_s1;
	logic [5:0]  rmi_s1;
	logic [5:0]  rs_s1;

	// controller state
	logic [15:0] tps_q;
	mode_t       mode_q;
	logic [2:0]  sfield_q;
	logic [1:0]  pfield_q;
	logic [7:0]  set_year_q;
	logic [3:0]  set_month_q;
	logic [4:0]  set_day_q;
	logic [5:0]  set_hms_q    [0:2];
	logic [5:0]  preset_hms_q [0:2];
	logic [5:0]  remain_hms_q [0:2];
	logic [6:0]  watch_hms_q  [0:2];
	logic [15:0] tick_q;
	logic        paused_q;
	logic        stopped_q;
	logic        alarm_q;

	// next state
	mode_t       nx_mode;
	logic [2:0]  nx_sfield;
	logic [1:0]  nx_pfield;
	logic [7:0]  nx_set_year;
	logic [3:0]  nx_set_month;
	logic [4:0]  nx_set_day;
	logic [5:0]  nx_set_hms    [0:2];
	logic [5:0]  nx_preset_hms [0:2];
	logic [5:0]  nx_remain_hms [0:2];
	logic [6:0]  nx_watch_hms  [0:2];
	logic [15:0] nx_tick;
	logic        nx_paused;
	logic        nx_stopped;
	logic        nx_alarm;
	logic        wr;

	logic [OUT_DATA_W-1:0] res_data;
	logic                  can_adv;
	logic                  adv;

	logic        run;
	logic [15:0] limit;
	logic [15:0] tick_inc;
	logic        fwd;

	assign can_adv  = !m_tvalid || m_tready;
	assign adv      = valid_s1 && can_adv;
	assign s_tready = !valid_s1 || can_adv;

	assign run      = (mode_q == MODE_RUN && !paused_q) || (mode_q == MODE_WATCH && !stopped_q);
	assign limit    = (tps_q == 16'd0) ? 16'd1 : tps_q;
	assign tick_inc = tick_q + 16'd1;
	assign fwd      = (op_s1 == OP_KNOB_FWD);

	always_comb begin
		nx_mode      = mode_q;
		nx_sfield    = sfield_q;
		nx_pfield    = pfield_q;
		nx_set_year  = set_year_q;
		nx_set_month = set_month_q;
		nx_set_day   = set_day_q;
		nx_set_hms    = set_hms_q;
		nx_preset_hms = preset_hms_q;
		nx_remain_hms = remain_hms_q;
		nx_watch_hms  = watch_hms_q;
		nx_tick      = tick_q;
		nx_paused    = paused_q;
		nx_stopped   = stopped_q;
		nx_alarm     = alarm_q;
		wr           = 1'b0;

		unique case (op_s1)
			OP_TICK: begin
				if (run) begin
					if (tick_inc != 16'd0 && tick_inc < limit) begin
						nx_tick = tick_inc;
					end else begin
						nx_tick = 16'd0;
						if (mode_q == MODE_RUN) begin
							if (remain_hms_q[2] != 6'd0) begin
								nx_remain_hms[2] = remain_hms_q[2] - 6'd1;
							end else if (remain_hms_q[1] != 6'd0 || remain_hms_q[0] != 6'd0) begin
								nx_remain_hms[2] = MS_MAX;
								if (remain_hms_q[1] != 6'd0) begin
									nx_remain_hms[1] = remain_hms_q[1] - 6'd1;
								end else begin
									nx_remain_hms[1] = MS_MAX;
									nx_remain_hms[0] = remain_hms_q[0] - 6'd1;
								end
							end else begin
								// underflow: alarm, back to preset
								nx_alarm = 1'b1;
								nx_mode  = MODE_PRESET;
							end
						end else begin
							if (watch_hms_q[2] + 7'd1 >= 7'd60) begin
								nx_watch_hms[2] = 7'd0;
								if (watch_hms_q[1] + 7'd1 >= 7'd60) begin
									nx_watch_hms[1] = 7'd0;
									nx_watch_hms[0] = (watch_hms_q[0] >= WATCH_HOUR_MAX) ?
										7'd0 : watch_hms_q[0] + 7'd1;
								end else begin
									nx_watch_hms[1] = watch_hms_q[1] + 7'd1;
								end
							end else begin
								nx_watch_hms[2] = watch_hms_q[2] + 7'd1;
							end
						end
					end
				end
			end
			OP_KNOB_FWD, OP_KNOB_BWD: begin
				if (mode_q == MODE_SETTING) begin
					case (sfield_q)
						SF_YEAR: begin
							if (fwd) begin
								nx_set_year = (set_year_q >= YEAR_MAX) ? YEAR_MAX : set_year_q + 8'd1;
							end else begin
								nx_set_year = (set_year_q <= YEAR_MIN) ? YEAR_MIN : set_year_q - 8'd1;
							end
						end
						SF_MONTH: nx_set_month = 4'(step_wrap({2'b00, set_month_q}, 6'd0, MONTH_MAX, fwd));
						SF_DAY:   nx_set_day = 5'(step_wrap({1'b0, set_day_q}, DAY_MIN, DAY_MAX, fwd));
						SF_HOUR:   nx_set_hms[0] = step_wrap(set_hms_q[0], 6'd0, HOUR_MAX, fwd);
						SF_MINUTE: nx_set_hms[1] = step_wrap(set_hms_q[1], 6'd0, MS_MAX, fwd);
						SF_SECOND: nx_set_hms[2] = step_wrap(set_hms_q[2], 6'd0, MS_MAX, fwd);
						default: ;
					endcase
				end else if (mode_q == MODE_PRESET) begin
					case (pfield_q)
						PF_HOUR:   nx_preset_hms[0] = step_wrap(preset_hms_q[0], 6'd0, HOUR_MAX, fwd);
						PF_MINUTE: nx_preset_hms[1] = step_wrap(preset_hms_q[1], 6'd0, MS_MAX, fwd);
						PF_SECOND: nx_preset_hms[2] = step_wrap(preset_hms_q[2], 6'd0, MS_MAX, fwd);
						default: ;
					endcase
				end
			end
			OP_KNOB_PRS: begin
				if (mode_q == MODE_NORMAL) begin
					nx_set_year   = ry_s1;
					nx_set_month  = rmo_s1;
					nx_set_day    = rd_s1;
					nx_set_hms[0] = {1'b0, rh_s1};
					nx_set_hms[1] = rmi_s1;
					nx_set_hms[2] = rs_s1;
					nx_sfield     = SF_YEAR;
					nx_mode       = MODE_SETTING;
				end else if (mode_q == MODE_SETTING) begin
					if (sfield_q >= SF_SECOND) begin
						wr      = 1'b1;
						nx_mode = MODE_NORMAL;
					end else begin
						nx_sfield = sfield_q + 3'd1;
					end
				end else if (mode_q == MODE_PRESET) begin
					if (pfield_q >= PF_SECOND) begin
						nx_remain_hms = preset_hms_q;
						nx_tick   = 16'd0;
						nx_pfield = PF_HOUR;
						nx_alarm  = 1'b0;
						nx_mode   = MODE_RUN;
					end else begin
						nx_pfield = pfield_q + 2'd1;
					end
				end
			end
			OP_KEY_ONE: begin
				if (mode_q == MODE_NORMAL) begin
					nx_mode          = MODE_PRESET;
					nx_preset_hms[0] = 6'd0;
					nx_preset_hms[1] = 6'd0;
					nx_preset_hms[2] = 6'd0;
				end else if (mode_q == MODE_RUN) begin
					nx_paused = !paused_q;
				end else if (mode_q == MODE_WATCH) begin
					nx_stopped = !stopped_q;
				end
			end
			OP_KEY_TWO: begin
				if (mode_q == MODE_PRESET) begin
					nx_mode  = MODE_NORMAL;
					nx_alarm = 1'b0;
				end else if (mode_q == MODE_NORMAL) begin
					nx_watch_hms[0] = 7'd0;
					nx_watch_hms[1] = 7'd0;
					nx_watch_hms[2] = 7'd0;
					nx_tick = 16'd0;
					nx_mode = MODE_WATCH;
				end else if (mode_q == MODE_WATCH) begin
					nx_mode    = MODE_NORMAL;
					nx_stopped = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// result view of the updated state
	logic [2:0] r_cursor;
	logic [7:0] r_year;
	logic [3:0] r_month;
	logic [4:0] r_day;
	logic [6:0] r_hour;
	logic [5:0] r_min;
	logic [5:0] r_sec;
	logic       r_hold;

	always_comb begin
		r_cursor = 3'd0;
		r_year   = ry_s1;
		r_month  = rmo_s1;
		r_day    = rd_s1;
		r_hour   = {2'b00, rh_s1};
		r_min    = rmi_s1;
		r_sec    = rs_s1;
		r_hold   = 1'b0;
		if (nx_mode == MODE_SETTING || wr) begin
			r_year  = nx_set_year;
			r_month = nx_set_month;
			r_day   = nx_set_day;
			r_hour  = {1'b0, nx_set_hms[0]};
			r_min   = nx_set_hms[1];
			r_sec   = nx_set_hms[2];
			if (nx_mode == MODE_SETTING) begin
				r_cursor = nx_sfield;
			end
		end else if (nx_mode == MODE_PRESET) begin
			r_hour   = {1'b0, nx_preset_hms[0]};
			r_min    = nx_preset_hms[1];
			r_sec    = nx_preset_hms[2];
			r_cursor = {1'b0, nx_pfield} + 3'd3;
		end else if (nx_mode == MODE_RUN) begin
			r_hour = {1'b0, nx_remain_hms[0]};
			r_min  = nx_remain_hms[1];
			r_sec  = nx_remain_hms[2];
			r_hold = nx_paused;
		end else if (nx_mode == MODE_WATCH) begin
			r_hour = nx_watch_hms[0];
			r_min  = nx_watch_hms[1][5:0];
			r_sec  = nx_watch_hms[2][5:0];
			r_hold = nx_stopped;
		end
	end

	assign res_data = {6'd0, nx_alarm, r_hold, wr, r_sec, r_min, r_hour, r_day, r_month,
		r_year, r_cursor};

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1  <= s_tuser;
			ry_s1  <= s_tdata[7:0];
			rmo_s1 <= s_tdata[11:8];
			rd_s1  <= s_tdata[16:12];
			rh_s1  <= s_tdata[21:17];
			rmi_s1 <= s_tdata[27:22];
			rs_s1  <= s_tdata[33:28];
		end
	end

	// control state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q           <= TPS_RESET;
			mode_q          <= MODE_NORMAL;
			sfield_q        <= SF_YEAR;
			pfield_q        <= PF_HOUR;
			preset_hms_q[0] <= 6'd0;
			preset_hms_q[1] <= 6'd0;
			preset_hms_q[2] <= 6'd0;
			remain_hms_q[0] <= 6'd0;
			remain_hms_q[1] <= 6'd0;
			remain_hms_q[2] <= 6'd0;
			watch_hms_q[0]  <= 7'd0;
			watch_hms_q[1]  <= 7'd0;
			watch_hms_q[2]  <= 7'd0;
			tick_q          <= 16'd0;
			paused_q        <= 1'b0;
			stopped_q       <= 1'b1;
			alarm_q         <= 1'b0;
			m_tvalid        <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				tps_q <= cfg_wr_data;
			end
			if (adv) begin
				mode_q       <= nx_mode;
				sfield_q     <= nx_sfield;
				pfield_q     <= nx_pfield;
				preset_hms_q <= nx_preset_hms;
				remain_hms_q <= nx_remain_hms;
				watch_hms_q  <= nx_watch_hms;
				tick_q       <= nx_tick;
				paused_q     <= nx_paused;
				stopped_q    <= nx_stopped;
				alarm_q      <= nx_alarm;
			end
			if (can_adv) begin
				m_tvalid <= valid_s1;
			end
		end
	end

	// setting values and result payload: written before use, no reset
	always_ff @(posedge clk) begin
		if (adv) begin
			set_year_q   <= nx_set_year;
			set_month_q  <= nx_set_month;
			set_day_q    <= nx_set_day;
			set_hms_q    <= nx_set_hms;
			m_tuser      <= nx_mode;
			m_tdata      <= res_data;
		end
	end

	// alarm is only raised on the way into preset and cleared on leaving it
	a_alarm_in_preset: assert property (@(posedge clk) disable iff (!arst_n)
		alarm_q |-> mode_q == MODE_PRESET)
		else $error("alarm active outside preset mode");

	a_write_normal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[39] |-> m_tuser == MODE_NORMAL)
		else $error("rtc write item not in normal mode");

	a_hold_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[40] |-> m_tuser == MODE_RUN || m_tuser == MODE_WATCH)
		else $error("hold lamp outside countdown or stopwatch");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && m_tvalid && !m_tready)
		else $error("input stalled without a blocked result");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clock set / countdown / stopwatch controller testbench
// Drives event items with random RTC readings and random idle and stall gaps
// on both streams. A scoreboard class keeps its own copy of the controller
// state, predicts the display item for every accepted event and compares each
// returned item field by field. Runs cover stopwatch ticks at the reset tick
// rate, a directed pass over field wraps, countdown expiry and a minute
// borrow, and mode-aware random sessions at several tick rates.
// ----------------------------------------------------------------------------
module tb_top;
	import csc_pkg::*;

	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;
	localparam int QUIET_LIMIT = 2000;
	localparam int CYCLES_PER_RUN = 120;
	localparam longint COUNTDOWN_BUDGET = 120;
	localparam int RESET_RATE_TICKS = 40;

	typedef enum logic [2:0] {
		MODE_NORMAL    = 3'd0,
		MODE_SETTING   = 3'd1,
		MODE_PRESET    = 3'd2,
		MODE_COUNTDOWN = 3'd3,
		MODE_STOPWATCH = 3'd4
	} mode_e;

	// packed so that year lands in the low bits of s_tdata
	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [4:0] day;
		logic [3:0] month;
		logic [7:0] year;
	} rtc_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [2:0] cursor;
		logic [7:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [6:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic       rtc_write;
		logic       hold;
		logic       alarm;
	} display_t;

	class display_scoreboard;
		logic [15:0] rate;
		mode_e       mode;
		logic [2:0]  set_field;
		logic [1:0]  pre_field;
		logic [7:0]  set_year;
		logic [3:0]  set_month;
		logic [4:0]  set_day;
		logic [5:0]  set_hms [3];
		logic [5:0]  preset_hms [3];
		logic [5:0]  remain_hms [3];
		logic [6:0]  watch_hms [3];
		logic [15:0] tick_cnt;
		bit          paused;
		bit          stopped;
		bit          alarm_on;
		display_t    display_q [$];
		int          errors;
		int          n_results;

		function new();
			rate = TPS_RESET;
			mode = MODE_NORMAL;
			set_field = SF_YEAR;
			pre_field = PF_HOUR;
			set_year = '0;
			set_month = '0;
			set_day = '0;
			for (int i = 0; i < 3; i++) begin
				set_hms[i] = '0;
				preset_hms[i] = '0;
				remain_hms[i] = '0;
				watch_hms[i] = '0;
			end
			tick_cnt = '0;
			paused = 1'b0;
			stopped = 1'b1;
			alarm_on = 1'b0;
			errors = 0;
			n_results = 0;
		endfunction

		function int knob_wrap(int v, int lo, int hi, bit fwd);
			if (fwd) begin
				return (v >= hi) ? lo : v + 1;
			end
			return (v <= lo) ? hi : v - 1;
		endfunction

		function void turn_knob(bit fwd);
			if (mode == MODE_SETTING) begin
				case (set_field)
					SF_YEAR: begin
						if (fwd) begin
							set_year = (set_year >= YEAR_MAX) ? YEAR_MAX : set_year + 8'd1;
						end else begin
							set_year = (set_year <= YEAR_MIN) ? YEAR_MIN : set_year - 8'd1;
						end
					end
					SF_MONTH:  set_month = 4'(knob_wrap(set_month, 0, MONTH_MAX, fwd));
					SF_DAY:    set_day = 5'(knob_wrap(set_day, DAY_MIN, DAY_MAX, fwd));
					SF_HOUR:   set_hms[0] = 6'(knob_wrap(set_hms[0], 0, HOUR_MAX, fwd));
					SF_MINUTE: set_hms[1] = 6'(knob_wrap(set_hms[1], 0, MS_MAX, fwd));
					SF_SECOND: set_hms[2] = 6'(knob_wrap(set_hms[2], 0, MS_MAX, fwd));
					default: ;
				endcase
			end else if (mode == MODE_PRESET) begin
				case (pre_field)
					PF_HOUR:   preset_hms[0] = 6'(knob_wrap(preset_hms[0], 0, HOUR_MAX, fwd));
					PF_MINUTE: preset_hms[1] = 6'(knob_wrap(preset_hms[1], 0, MS_MAX, fwd));
					PF_SECOND: preset_hms[2] = 6'(knob_wrap(preset_hms[2], 0, MS_MAX, fwd));
					default: ;
				endcase
			end
		endfunction

		// one second off the countdown; at 0:0:0 it expires instead
		function void count_down_one();
			if (remain_hms[2] != 0) begin
				remain_hms[2]--;
			end else if (remain_hms[1] != 0 || remain_hms[0] != 0) begin
				remain_hms[2] = MS_MAX;
				if (remain_hms[1] != 0) begin
					remain_hms[1]--;
				end else begin
					remain_hms[1] = MS_MAX;
					remain_hms[0]--;
				end
			end else begin
				alarm_on = 1'b1;
				mode = MODE_PRESET;
			end
		endfunction

		function void stopwatch_second();
			if (watch_hms[2] >= 7'(MS_MAX)) begin
				watch_hms[2] = '0;
				if (watch_hms[1] >= 7'(MS_MAX)) begin
					watch_hms[1] = '0;
					watch_hms[0] = (watch_hms[0] >= WATCH_HOUR_MAX) ? 7'd0 : watch_hms[0] + 7'd1;
				end else begin
					watch_hms[1]++;
				end
			end else begin
				watch_hms[2]++;
			end
		endfunction

		function void take_tick();
			int limit;
			if (!((mode == MODE_COUNTDOWN && !paused) || (mode == MODE_STOPWATCH && !stopped))) begin
				return;
			end
			limit = (rate == 0) ? 1 : int'(rate);
			tick_cnt = tick_cnt + 16'd1;
			// a count left above a lowered rate also ends the second
			if (tick_cnt != 0 && int'(tick_cnt) < limit) begin
				return;
			end
			tick_cnt = '0;
			if (mode == MODE_COUNTDOWN) begin
				count_down_one();
			end else begin
				stopwatch_second();
			end
		endfunction

		function void note_event(logic [2:0] op, rtc_t r);
			display_t e;
			bit wr;
			wr = 1'b0;
			case (op)
				OP_TICK:     take_tick();
				OP_KNOB_FWD: turn_knob(1'b1);
				OP_KNOB_BWD: turn_knob(1'b0);
				OP_KNOB_PRS: begin
					case (mode)
						MODE_NORMAL: begin
							set_year = r.year;
							set_month = r.month;
							set_day = r.day;
							set_hms[0] = 6'(r.hour);
							set_hms[1] = r.minute;
							set_hms[2] = r.second;
							set_field = SF_YEAR;
							mode = MODE_SETTING;
						end
						MODE_SETTING: begin
							if (set_field >= SF_SECOND) begin
								wr = 1'b1;
								mode = MODE_NORMAL;
							end else begin
								set_field++;
							end
						end
						MODE_PRESET: begin
							if (pre_field >= PF_SECOND) begin
								remain_hms = preset_hms;
								tick_cnt = '0;
								pre_field = PF_HOUR;
								alarm_on = 1'b0;
								mode = MODE_COUNTDOWN;
							end else begin
								pre_field++;
							end
						end
						default: ;
					endcase
				end
				OP_KEY_ONE: begin
					case (mode)
						MODE_NORMAL: begin
							mode = MODE_PRESET;
							preset_hms = '{default: '0};
						end
						MODE_COUNTDOWN: paused = !paused;
						MODE_STOPWATCH: stopped = !stopped;
						default: ;
					endcase
				end
				OP_KEY_TWO: begin
					case (mode)
						MODE_PRESET: begin
							mode = MODE_NORMAL;
							alarm_on = 1'b0;
						end
						MODE_NORMAL: begin
							watch_hms = '{default: '0};
							tick_cnt = '0;
							mode = MODE_STOPWATCH;
						end
						MODE_STOPWATCH: begin
							mode = MODE_NORMAL;
							stopped = 1'b1;
						end
						default: ;
					endcase
				end
				default: ;
			endcase

			e.mode = mode;
			e.cursor = '0;
			e.year = r.year;
			e.month = r.month;
			e.day = r.day;
			e.hour = 7'(r.hour);
			e.minute = r.minute;
			e.second = r.second;
			e.rtc_write = wr;
			e.hold = 1'b0;
			e.alarm = alarm_on;
			if (mode == MODE_SETTING || wr) begin
				e.year = set_year;
				e.month = set_month;
				e.day = set_day;
				e.hour = 7'(set_hms[0]);
				e.minute = set_hms[1];
				e.second = set_hms[2];
				if (mode == MODE_SETTING) begin
					e.cursor = set_field;
				end
			end else if (mode == MODE_PRESET) begin
				e.hour = 7'(preset_hms[0]);
				e.minute = preset_hms[1];
				e.second = preset_hms[2];
				e.cursor = 3'(pre_field) + 3'd3;
			end else if (mode == MODE_COUNTDOWN) begin
				e.hour = 7'(remain_hms[0]);
				e.minute = remain_hms[1];
				e.second = remain_hms[2];
				e.hold = paused;
			end else if (mode == MODE_STOPWATCH) begin
				e.hour = watch_hms[0];
				e.minute = watch_hms[1][5:0];
				e.second = watch_hms[2][5:0];
				e.hold = stopped;
			end
			display_q.push_back(e);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 100) begin
				$display("ERROR @%0t: %s", $realtime, msg);
			end
		endtask

		task cmp_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want) begin
				report($sformatf("item %0d: %s is %0d, expected %0d", n_results, name, got, want));
			end
		endtask

		task check_result(logic [2:0] got_mode, logic [OUT_DATA_W-1:0] d);
			display_t e;
			n_results++;
			if (display_q.size() == 0) begin
				report($sformatf("item %0d: display item with no event waiting", n_results));
				return;
			end
			e = display_q.pop_front();
			cmp_field("mode", 8'(got_mode), 8'(e.mode));
			cmp_field("cursor_field", 8'(d[2:0]), 8'(e.cursor));
			cmp_field("disp_year", d[10:3], e.year);
			cmp_field("disp_month", 8'(d[14:11]), 8'(e.month));
			cmp_field("disp_day", 8'(d[19:15]), 8'(e.day));
			cmp_field("disp_hour", 8'(d[26:20]), 8'(e.hour));
			cmp_field("disp_minute", 8'(d[32:27]), 8'(e.minute));
			cmp_field("disp_second", 8'(d[38:33]), 8'(e.second));
			cmp_field("rtc_write", 8'(d[39]), 8'(e.rtc_write));
			cmp_field("hold_lamp", 8'(d[40]), 8'(e.hold));
			cmp_field("alarm", 8'(d[41]), 8'(e.alarm));
			cmp_field("zero fill", 8'(d[47:42]), 8'd0);
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [15:0]           cfg_wr_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [2:0]            s_tuser = OP_TICK;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [2:0]            m_tuser;
	logic [OUT_DATA_W-1:0] m_tdata;

	display_scoreboard sb = new();
	bit steady = 1'b1;
	int quiet_cycles = 0;
	int stall_left = 0;
	logic [15:0] rate_plan [8] = '{16'd1, 16'd0, 16'd2, 16'd3, 16'd1000, 16'hFFFF, 16'd5, 16'd7};

	clock_set_countdown_stopwatch_ctrl_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tuser     (s_tuser),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tuser     (m_tuser),
		.m_tdata     (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (steady || r < 60) begin
			return 0;
		end else if (r < 88) begin
			return $urandom_range(3, 1);
		end else if (r < 97) begin
			return $urandom_range(12, 4);
		end
		return $urandom_range(60, 20);
	endfunction

	function automatic rtc_t random_rtc();
		rtc_t r;
		if ($urandom_range(9) == 0) begin
			// out-of-range readings reach the knob wraps from above the top
			r.year = 8'($urandom);
			r.month = 4'($urandom);
			r.day = 5'($urandom);
			r.hour = 5'($urandom);
			r.minute = 6'($urandom);
			r.second = 6'($urandom);
		end else begin
			r.year = 8'($urandom_range(199, 70));
			r.month = 4'($urandom_range(11));
			r.day = 5'($urandom_range(31, 1));
			r.hour = 5'($urandom_range(23));
			r.minute = 6'($urandom_range(59));
			r.second = 6'($urandom_range(59));
		end
		return r;
	endfunction

	// ticks a countdown from the preset would need before it expires
	function automatic longint countdown_cost();
		longint secs;
		secs = sb.preset_hms[0] * 3600 + sb.preset_hms[1] * 60 + sb.preset_hms[2] + 1;
		return secs * ((sb.rate == 0) ? 1 : sb.rate);
	endfunction

	// picks an event that keeps the session moving through the modes
	function automatic logic [2:0] choose_event();
		int r;
		logic [2:0] any_op;
		r = $urandom_range(99);
		any_op = 3'($urandom_range(7));
		case (sb.mode)
			MODE_NORMAL: begin
				if (r < 25) return OP_KNOB_PRS;
				if (r < 50) return OP_KEY_ONE;
				if (r < 75) return OP_KEY_TWO;
			end
			MODE_SETTING: begin
				if (r < 30) return OP_KNOB_FWD;
				if (r < 60) return OP_KNOB_BWD;
				if (r < 90) return OP_KNOB_PRS;
			end
			MODE_PRESET: begin
				if (r < 25) return OP_KNOB_FWD;
				if (r < 45) return OP_KNOB_BWD;
				if (r < 90) begin
					if (r >= 80 || (sb.pre_field >= PF_SECOND &&
							countdown_cost() > COUNTDOWN_BUDGET)) begin
						return OP_KEY_TWO;
					end
					return OP_KNOB_PRS;
				end
				// keep a long countdown from starting by accident
				if (any_op == OP_KNOB_PRS) return OP_TICK;
			end
			MODE_COUNTDOWN: begin
				if (r < 85) return OP_TICK;
				if (r < 93) return OP_KEY_ONE;
			end
			MODE_STOPWATCH: begin
				if (r < 65) return OP_TICK;
				if (r < 82) return OP_KEY_ONE;
				if (r < 90) return OP_KEY_TWO;
			end
			default: ;
		endcase
		return any_op;
	endfunction

	// called and returns at a falling edge; s_tvalid stays up for a back-to-back item
	task automatic put_item(input logic [2:0] op, input rtc_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{(IN_DATA_W - $bits(rtc_t)){1'b0}}, r};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic put_op(input logic [2:0] op);
		put_item(op, random_rtc());
	endtask

	task automatic run_out_countdown();
		while (sb.mode == MODE_COUNTDOWN) begin
			put_op(sb.paused ? OP_KEY_ONE : OP_TICK);
		end
	endtask

	task automatic return_to_normal();
		while (sb.mode != MODE_NORMAL) begin
			case (sb.mode)
				MODE_SETTING:   put_op(OP_KNOB_PRS);
				MODE_COUNTDOWN: run_out_countdown();
				default:        put_op(OP_KEY_TWO);
			endcase
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.display_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// a running countdown is finished first so a slow rate cannot strand it;
	// a running stopwatch is left going on purpose
	task automatic set_rate(input logic [15:0] v);
		run_out_countdown();
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.rate = v;
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			sb.note_event(s_tuser, rtc_t'(s_tdata[$bits(rtc_t)-1:0]));
		end
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tuser, m_tdata);
		end
		if (arst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		rtc_t rtc_top;
		rtc_t rtc_bottom;
		rtc_t rtc_mix;
		rtc_top = '{second: 6'd59, minute: 6'd59, hour: 5'd23, day: 5'd31, month: 4'd11,
			year: 8'd199};
		rtc_bottom = '{second: 6'd0, minute: 6'd0, hour: 5'd0, day: 5'd1, month: 4'd0,
			year: 8'd70};
		// each field sits at the end that its knob step then wraps or saturates
		rtc_mix = '{second: 6'd0, minute: 6'd59, hour: 5'd0, day: 5'd31, month: 4'd0,
			year: 8'd199};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset tick rate: stopwatch ticks that stay short of one second
		put_op(OP_KEY_TWO);
		put_op(OP_KEY_ONE);
		repeat (RESET_RATE_TICKS) put_op(OP_TICK);
		put_op(OP_KEY_TWO);

		set_rate(16'd1);
		steady = 1'b0;

		put_item(OP_SPARE_A, rtc_top);
		put_item(OP_SPARE_B, rtc_bottom);
		put_item(OP_KNOB_PRS, rtc_mix);
		put_op(OP_KNOB_FWD);
		put_op(OP_KNOB_PRS);
		put_op(OP_KNOB_BWD);
		put_op(OP_KNOB_PRS);
		put_op(OP_KNOB_FWD);
		put_op(OP_KNOB_PRS);
		put_op(OP_KNOB_BWD);
		put_op(OP_KNOB_PRS);
		put_op(OP_KNOB_FWD);
		put_op(OP_KNOB_PRS);
		put_op(OP_KNOB_BWD);
		put_op(OP_KNOB_PRS);

		// countdown from 0:0:1 with a pause, then expiry
		put_op(OP_KEY_ONE);
		put_op(OP_KNOB_PRS);
		put_op(OP_KNOB_PRS);
		put_op(OP_KNOB_FWD);
		put_op(OP_KNOB_PRS);
		put_op(OP_KEY_ONE);
		put_op(OP_TICK);
		put_op(OP_KEY_ONE);
		put_op(OP_TICK);
		put_op(OP_TICK);
		put_op(OP_KEY_TWO);

		// minute borrow: 0:1:0 down to expiry
		put_op(OP_KEY_ONE);
		put_op(OP_KNOB_PRS);
		put_op(OP_KNOB_FWD);
		put_op(OP_KNOB_PRS);
		put_op(OP_KNOB_PRS);
		run_out_countdown();
		put_op(OP_KEY_TWO);

		foreach (rate_plan[i]) begin
			set_rate(rate_plan[i]);
			steady = ($urandom_range(3) == 0);
			repeat (CYCLES_PER_RUN) put_op(choose_event());
		end

		steady = 1'b1;
		return_to_normal();

		drain();
		repeat (10) @(negedge clk);
		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
